/* sv/pdbg_pkg.sv */
`timescale 1ns / 1ps

package pdbg_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_RD1,
        S_RD0
    } pdbg_state_t;

    // register indexes on the configuration port
    localparam logic REG_WORD_BITS = 1'b0;

    // width of the word length register
    localparam int unsigned WBITS_W = 4;

    // commands from controller to datapath
    typedef struct packed {
        logic init_step;     // reset sweep: write zero at sweep address
        logic clr_step;      // restart sweep: clear entry, mark word zero
        logic rd_zero;       // read the append-0 candidate
        logic mark_one;      // take the append-1 candidate
        logic mark_zero;     // take the append-0 candidate
        logic emit_restart;  // load the restart word into the output
        logic emit_exh;      // load an exhausted word into the output
    } pdbg_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic go_restart;    // incoming word starts the sequence anew
        logic go_exh;        // sequence already complete
        logic clr_at_mask;   // sweep address at the last entry of the code
        logic clr_at_top;    // sweep address at the last entry of the map
        logic rd_hit;        // candidate read back as visited
        logic out_free;      // output register can take a word
    } pdbg_sts_t;

endpackage

/* sv/prefer_one_debruijn_generator.sv */
`timescale 1ns / 1ps

// prefer-one de bruijn word generator
// input channel (in_valid/in_ready, restart): each word asks for the next code word,
// or with restart set starts the sequence anew from the all-zero word
// output channel (out_valid/out_ready): one word per request with code_word,
// word_index, is_last and exhausted; a request past the end returns exhausted
// configuration: word_bits at byte address 0 sets the code length n (1..MAX_BITS)
// steps: a plain request reads the append-1 candidate in S_RD1 and, when that is
// visited, the append-0 candidate in S_RD0; a restart first sweeps S_CLEAR over
// the 2^n map entries, clearing the visited map one entry a cycle; a request past
// the end answers at the edge where it is accepted
// one request in flight: a new request is taken only in S_IDLE; the visited map
// is a single memory with one read and one write port, read data registered
// reset: the map is swept clear over all 2^MAX_BITS entries, in_ready low meanwhile;
// the first request after reset acts as a restart
// stall: a result waits in the output register; a new request is taken in the cycle
// the waiting result is taken, never earlier
module prefer_one_debruijn_generator
    import pdbg_pkg::*;
#(
    parameter int MAX_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MAX_BITS-1:0] code_word,
    output logic [MAX_BITS-1:0] word_index,
    output logic                is_last,
    output logic                exhausted,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [WBITS_W-1:0] word_bits_reg;
    logic [WBITS_W-1:0] word_bits_next;
    logic               cfg_wr;
    pdbg_cmd_t          cmd;
    pdbg_sts_t          sts;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WORD_BITS);

    always_comb
    begin
        word_bits_next = word_bits_reg;
        if (cfg_wr)
        begin
            word_bits_next = pwdata[WBITS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg <= WBITS_W'(4);
        end
        else
        begin
            word_bits_reg <= word_bits_next;
        end
    end

    // register read-back
    assign prdata = (paddr[2] == REG_WORD_BITS) ? 32'(word_bits_reg) : '0;

    pdbg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdbg_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_bits  (word_bits_reg),
        .restart    (restart),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_word  (code_word),
        .word_index (word_index),
        .is_last    (is_last),
        .exhausted  (exhausted)
    );

endmodule

/* sv/pdbg_ctrl.sv */
`timescale 1ns / 1ps

module pdbg_ctrl
    import pdbg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pdbg_sts_t sts,
    output pdbg_cmd_t cmd
);

    pdbg_state_t state_reg;
    pdbg_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.clr_at_top)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    priority if (sts.go_restart)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (sts.go_exh)
                    begin
                        cmd.emit_exh = 1'b1;
                    end
                    else
                    begin
                        // append-1 candidate is read by default
                        state_next = S_RD1;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_at_mask)
                begin
                    cmd.emit_restart = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_RD1:
            begin
                if (!sts.rd_hit)
                begin
                    cmd.mark_one = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_zero = 1'b1;
                    state_next  = S_RD0;
                end
            end
            S_RD0:
            begin
                if (!sts.rd_hit)
                begin
                    cmd.mark_zero = 1'b1;
                end
                else
                begin
                    cmd.emit_exh = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

/* sv/pdbg_dp.sv */
`timescale 1ns / 1ps

module pdbg_dp
    import pdbg_pkg::*;
#(
    parameter int MAX_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WBITS_W-1:0]  word_bits,
    input  logic                restart,
    input  pdbg_cmd_t           cmd,
    output pdbg_sts_t           sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MAX_BITS-1:0] code_word,
    output logic [MAX_BITS-1:0] word_index,
    output logic                is_last,
    output logic                exhausted
);

    localparam int DEPTH = 1 << MAX_BITS;
    localparam int NW    = WBITS_W + 1;
    localparam logic [NW-1:0] MaxN = NW'(MAX_BITS);

    // visited map
    logic mem [DEPTH];

    logic [MAX_BITS-1:0] clr_addr_reg;
    logic [MAX_BITS-1:0] clr_addr_next;
    logic [MAX_BITS-1:0] cur_reg;
    logic [MAX_BITS-1:0] cur_next;
    logic [MAX_BITS:0]   count_reg;
    logic [MAX_BITS:0]   count_next;
    logic                rd_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [MAX_BITS-1:0] code_reg;
    logic [MAX_BITS-1:0] index_reg;
    logic                last_reg;
    logic                exh_reg;

    logic [NW-1:0]       n_eff;
    logic [MAX_BITS:0]   size;
    logic [MAX_BITS-1:0] mask;
    logic [MAX_BITS-1:0] cand1;
    logic [MAX_BITS-1:0] cand0;
    logic [MAX_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [MAX_BITS-1:0] wr_addr;
    logic                wr_data;
    logic                emit;

    // effective word length, clamped to 1..MAX_BITS
    always_comb
    begin
        n_eff = NW'(word_bits);
        priority if (word_bits == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(word_bits) > MaxN)
        begin
            n_eff = MaxN;
        end
        else
        begin
            n_eff = NW'(word_bits);
        end
    end

    assign size  = (MAX_BITS+1)'(1) << n_eff;
    assign mask  = MAX_BITS'(size - (MAX_BITS+1)'(1));
    assign cand1 = ((cur_reg << 1) | MAX_BITS'(1)) & mask;
    assign cand0 = (cur_reg << 1) & mask;

    // status towards the controller
    assign sts.go_restart  = restart || (count_reg == '0);
    assign sts.go_exh      = (count_reg >= size);
    assign sts.clr_at_mask = (clr_addr_reg == mask);
    assign sts.clr_at_top  = (clr_addr_reg == '1);
    assign sts.rd_hit      = rd_data_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // map port selection
    assign rd_addr = cmd.rd_zero ? cand0 : cand1;
    assign wr_en   = cmd.init_step | cmd.clr_step | cmd.mark_one | cmd.mark_zero;

    always_comb
    begin
        wr_addr = cand0;
        wr_data = 1'b1;
        priority if (cmd.init_step)
        begin
            wr_addr = clr_addr_reg;
            wr_data = 1'b0;
        end
        else if (cmd.clr_step)
        begin
            // word zero is marked as the sweep passes it
            wr_addr = clr_addr_reg;
            wr_data = (clr_addr_reg == '0);
        end
        else if (cmd.mark_one)
        begin
            wr_addr = cand1;
            wr_data = 1'b1;
        end
        else
        begin
            wr_addr = cand0;
            wr_data = 1'b1;
        end
    end

    // map write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // map read, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // sweep address, current word and count
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_step && (clr_addr_reg == mask))
        begin
            clr_addr_next = '0;
        end
        else if (cmd.init_step || cmd.clr_step)
        begin
            clr_addr_next = clr_addr_reg + MAX_BITS'(1);
        end

        cur_next   = cur_reg;
        count_next = count_reg;
        priority if (cmd.emit_restart)
        begin
            cur_next   = '0;
            count_next = (MAX_BITS+1)'(1);
        end
        else if (cmd.mark_one)
        begin
            cur_next   = cand1;
            count_next = count_reg + (MAX_BITS+1)'(1);
        end
        else if (cmd.mark_zero)
        begin
            cur_next   = cand0;
            count_next = count_reg + (MAX_BITS+1)'(1);
        end
        else
        begin
            cur_next   = cur_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            cur_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            cur_reg      <= cur_next;
            count_reg    <= count_next;
        end
    end

    // output word register
    assign emit = cmd.emit_restart | cmd.emit_exh | cmd.mark_one | cmd.mark_zero;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.emit_restart)
        begin
            code_reg  <= '0;
            index_reg <= '0;
            last_reg  <= (mask == '0);
            exh_reg   <= 1'b0;
        end
        else if (cmd.emit_exh)
        begin
            code_reg  <= '0;
            index_reg <= '0;
            last_reg  <= 1'b0;
            exh_reg   <= 1'b1;
        end
        else if (cmd.mark_one || cmd.mark_zero)
        begin
            code_reg  <= cmd.mark_one ? cand1 : cand0;
            index_reg <= count_reg[MAX_BITS-1:0];
            last_reg  <= (count_reg == {1'b0, mask});
            exh_reg   <= 1'b0;
        end
        else
        begin
            code_reg  <= code_reg;
            index_reg <= index_reg;
            last_reg  <= last_reg;
            exh_reg   <= exh_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_word  = code_reg;
    assign word_index = index_reg;
    assign is_last    = last_reg;
    assign exhausted  = exh_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb
    import pdbg_pkg::*;
;

    localparam int GEN_BITS    = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 30000;
    localparam int RAND_WORDS  = 650;
    localparam int REPORT_MAX  = 40;

    // one result word of the generator
    typedef struct packed {
        logic [GEN_BITS-1:0] code_word;
        logic [GEN_BITS-1:0] word_index;
        logic                is_last;
        logic                exhausted;
    } gen_word_t;

    typedef enum logic {
        ROW_SET,
        ROW_ASK
    } row_kind_t;

    // directed row: a length write or a request, with an optional typed-in answer
    typedef struct packed {
        row_kind_t  kind;
        logic [3:0] val;
        logic       typed;
        gen_word_t  want;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                restart   = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [GEN_BITS-1:0] code_word;
    logic [GEN_BITS-1:0] word_index;
    logic                is_last;
    logic                exhausted;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    // shadow of the generator state
    bit                  seen_word [1 << GEN_BITS];
    logic [GEN_BITS-1:0] last_word = '0;
    logic [GEN_BITS:0]   words_out = '0;
    logic [3:0]          len_reg   = 4'd4;

    gen_word_t expected_words [$];
    dir_row_t  dir_rows [25];
    int        err_cnt      = 0;
    int        snd_idle     = 0;
    int        rcv_stall    = 0;
    int        quiet_cycles = 0;
    int        hold_left    = 0;
    logic      hold_req     = 1'b0;
    logic      hold_ack     = 1'b0;

    prefer_one_debruijn_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_word  (code_word),
        .word_index (word_index),
        .is_last    (is_last),
        .exhausted  (exhausted),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // next prefer-one word for one request, updating the shadow state
    function automatic gen_word_t next_code_word(input logic rs);
        int unsigned         n;
        logic [GEN_BITS-1:0] mask;
        logic [GEN_BITS-1:0] cand;
        gen_word_t           w;
        n = 32'(len_reg);
        if (n < 1)
            n = 1;
        if (n > GEN_BITS)
            n = GEN_BITS;
        mask = GEN_BITS'((1 << n) - 1);
        w = '0;
        // restart, or the first request of all
        if (rs || words_out == '0)
        begin
            for (int i = 0; i <= int'(mask); i++)
                seen_word[i] = 1'b0;
            seen_word[0] = 1'b1;
            last_word = '0;
            words_out = (GEN_BITS+1)'(1);
            w.is_last = (mask == '0);
            return w;
        end
        // past the end of the sequence
        if (words_out > {1'b0, mask})
        begin
            w.exhausted = 1'b1;
            return w;
        end
        // prefer appending a one, fall back to a zero
        cand = {last_word[GEN_BITS-2:0], 1'b1} & mask;
        if (seen_word[cand])
        begin
            cand = {last_word[GEN_BITS-2:0], 1'b0} & mask;
            if (seen_word[cand])
            begin
                w.exhausted = 1'b1;
                return w;
            end
        end
        seen_word[cand] = 1'b1;
        last_word = cand;
        w.code_word  = cand;
        w.word_index = words_out[GEN_BITS-1:0];
        w.is_last    = (words_out == {1'b0, mask});
        words_out = words_out + (GEN_BITS+1)'(1);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // compare one received word with the oldest expected one
    task automatic check_word(input gen_word_t got);
        gen_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.code_word !== want.code_word)
            report_mismatch($sformatf("code_word %h, want %h", got.code_word, want.code_word));
        if (got.word_index !== want.word_index)
            report_mismatch($sformatf("word_index %h, want %h",
                                      got.word_index, want.word_index));
        if (got.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %b, want %b", got.is_last, want.is_last));
        if (got.exhausted !== want.exhausted)
            report_mismatch($sformatf("exhausted %b, want %b", got.exhausted, want.exhausted));
    endtask

    // offer one request word, with a random gap first
    task automatic send_word(input logic rs, input logic typed, input gen_word_t want);
        gen_word_t w;
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        w = next_code_word(rs);
        expected_words.push_back(typed ? want : w);
    endtask

    // stop offering and wait until every expected word is in
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // register write: setup then access cycle
    task automatic set_word_bits(input logic [3:0] v, input logic [27:0] hi);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WORD_BITS, 2'b00};
        pwdata  <= {hi, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        len_reg = v;
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_stall);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_word({code_word, word_index, is_last, exhausted});
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned seq_len;
        int unsigned n_pick;
        int unsigned eff;
        logic [3:0]  nb;
        logic        do_restart;

        dir_rows = '{
            // first request after reset behaves as a restart
            '{ROW_ASK, 4'd0,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            // shortest code: two words then past the end
            '{ROW_SET, 4'd1,  1'b0, '0},
            '{ROW_ASK, 4'd1,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b1, '{12'd1, 12'd1, 1'b1, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b1}},
            // zero length acts as one bit
            '{ROW_SET, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd1,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b1, '{12'd1, 12'd1, 1'b1, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b1}},
            // two bits: full code with the append-zero fallback, then past the end
            '{ROW_SET, 4'd2,  1'b0, '0},
            '{ROW_ASK, 4'd1,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            // length grows in the middle of a sequence
            '{ROW_SET, 4'd4,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0},
            // length above the maximum is clipped
            '{ROW_SET, 4'd15, 1'b0, '0},
            '{ROW_ASK, 4'd1,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
            '{ROW_ASK, 4'd0,  1'b1, '{12'd1, 12'd1, 1'b0, 1'b0}},
            '{ROW_SET, 4'd12, 1'b0, '0},
            '{ROW_ASK, 4'd0,  1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SET)
            begin
                wait_idle();
                set_word_bits(dir_rows[i].val, '0);
            end
            else
                send_word(dir_rows[i].val[0], dir_rows[i].typed, dir_rows[i].want);
        end

        // random sequences, one length setting per phase
        sent  = 0;
        phase = 0;
        while (sent < RAND_WORDS)
        begin
            wait_idle();
            unique case (phase % 4)
                0:
                begin
                    snd_idle  = 0;
                    rcv_stall = 0;
                end
                1:
                begin
                    snd_idle  = 72;
                    rcv_stall = 0;
                end
                2:
                begin
                    snd_idle  = 0;
                    rcv_stall = 72;
                end
                default:
                begin
                    snd_idle  = 25;
                    rcv_stall = 25;
                end
            endcase

            // mostly short codes, now and then the long or clipped ones
            n_pick = $urandom_range(99);
            if (n_pick < 2)
                nb = 4'd0;
            else if (n_pick < 8)
                nb = 4'($urandom_range(15, 12));
            else if (n_pick < 18)
                nb = 4'($urandom_range(11, 7));
            else
                nb = 4'($urandom_range(6, 1));
            set_word_bits(nb, 28'($urandom()));

            eff = (nb == 4'd0) ? 1 : ((32'(nb) > GEN_BITS) ? GEN_BITS : 32'(nb));
            seq_len = (eff <= 6) ? (1 << eff) + $urandom_range(3) : $urandom_range(40, 5);
            // most phases start afresh, the rest carry on under the new length
            do_restart = ($urandom_range(99) < 80);

            // long receiver hold-off while the sender keeps offering
            if ((phase % 4) == 2 || $urandom_range(99) < 6)
                hold_req <= ~hold_req;

            for (int k = 0; k < seq_len; k++)
            begin
                send_word((k == 0) ? do_restart : ($urandom_range(99) < 3), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
sv/pdbg_pkg.sv
sv/pdbg_ctrl.sv
sv/pdbg_dp.sv
sv/prefer_one_debruijn_generator.sv
tb/sv/tb.sv
